// ----- rtl/adcrb_pkg.sv -----
// adcrb_pkg: shared types and constants for the A/D converter register block.
// Used by adcrb_ctrl, adcrb_dp and adc_register_block_core. No dependencies.
`timescale 1ns / 1ps

package adcrb_pkg;

  localparam int CHANNELS = 5;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // address decode: clock register pair and 32-byte block
  localparam logic [10:0] CLK_PAGE = 11'h290;  // 0x520 >> 1
  localparam logic [6:0]  BLK_PAGE = 7'h2a;    // 0x540 >> 5

  // block register indexes (address bits 4..1)
  localparam logic [3:0] REG_STD   = 4'h0;
  localparam logic [3:0] REG_TRIG  = 4'h1;
  localparam logic [3:0] REG_CTRL  = 4'h2;
  localparam logic [3:0] REG_FLAGS = 4'h3;
  localparam logic [3:0] REG_BUF0  = 4'h4;
  localparam logic [3:0] REG_UPPER = 4'hc;
  localparam logic [3:0] REG_LOWER = 4'hd;
  localparam logic [3:0] REG_IMASK = 4'he;
  localparam logic [3:0] REG_ADV   = 4'hf;

  // configuration register indexes
  localparam logic [1:0] CFG_CH0   = 2'd0;
  localparam logic [1:0] CFG_CH1   = 2'd1;
  localparam logic [1:0] CFG_CH2   = 2'd2;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam logic [9:0] CH0_RESET   = 10'd832;
  localparam logic [9:0] CH1_RESET   = 10'd502;
  localparam logic [9:0] CH2_RESET   = 10'd512;
  localparam logic [9:0] SPARE_RESET = 10'd512;

  localparam logic [15:0] CTRL_RESET = 16'h0310;
  localparam logic [4:0]  IMASK_RESET = 5'h1f;
  localparam logic [15:0] TRIG_WMASK = 16'h3f38;
  localparam logic [15:0] CTRL_WMASK = 16'hf376;
  localparam logic [15:0] LIM_WMASK  = 16'h03ff;
  localparam logic [15:0] IMASK_WMASK = 16'h001f;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;   // capture input beat
    logic exec;   // perform the access
    logic step;   // convert one channel of the sweep
    logic emit;   // move result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_go;    // access starts a non-empty sweep
    logic sweep_last;  // current channel is the last one
  } dp_stat_t;

endpackage

// ----- rtl/adc_register_block_core.sv -----
// adc_register_block_core: top level of the A/D converter register block.
// Instantiates adcrb_ctrl and adcrb_dp; depends on adcrb_pkg.
// Flow: an accepted beat passes EXEC, then SWEEP for N channels, then RESP, where
//   N = channels converted by a start write (0 for every other access).
// Beats run one at a time; the sweep converts one channel per cycle.
// Reset: sync active-low rst_n resets state registers; payload registers have none.
`timescale 1ns / 1ps

module adc_register_block_core
  import adcrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel: one bus access per beat
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [11:0] in_address,
  input  logic [2:0]  in_size,
  input  logic [15:0] in_write_data,
  // response channel: one beat per request
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_data,
  output logic        out_handled,
  // fixed-count configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  // Flow per beat:
  //   IDLE  - request captured into the datapath
  //   EXEC  - decode, register read/write, done-flag clears; a start write
  //           with enable and software trigger loads the sweep range here
  //   SWEEP - one channel per cycle: buffer <= fixed count, flags updated
  //   RESP  - result moved to the output register once it is free
  // The output register decouples the two sides, so a new request is taken
  // while the previous response still waits for out_ready.

  dp_cmd_t  cmd;
  dp_stat_t stat;

  adcrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  adcrb_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (in_op),
    .in_address    (in_address),
    .in_size       (in_size),
    .in_write_data (in_write_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_read_data (out_read_data),
    .out_handled   (out_handled)
  );

endmodule

// ----- rtl/adcrb_ctrl.sv -----
// adcrb_ctrl: sequencer for the A/D converter register block.
// Depends on adcrb_pkg; drives commands into adcrb_dp.
`timescale 1ns / 1ps

module adcrb_ctrl
  import adcrb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.sweep_go ? S_SWEEP : S_RESP;
      end
      S_SWEEP: begin
        cmd.step = 1'b1;
        if (stat.sweep_last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.emit)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // an accepted beat is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted beat not executed");

  // the sweep ends on its last channel
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && stat.sweep_last) |=> (state_r == S_RESP))
    else $error("sweep did not end");

endmodule

// ----- rtl/adcrb_dp.sv -----
// adcrb_dp: register file, access decode and channel sweep datapath.
// Depends on adcrb_pkg; sequenced by adcrb_ctrl.
`timescale 1ns / 1ps

module adcrb_dp
  import adcrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        in_op,
  input  logic [11:0] in_address,
  input  logic [2:0]  in_size,
  input  logic [15:0] in_write_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output logic [15:0] out_read_data,
  output logic        out_handled
);

  // captured access
  logic        op_r;
  logic [11:0] addr_r;
  logic [2:0]  size_r;
  logic [15:0] wd_r;

  // fixed conversion counts
  logic [9:0] ch0_cnt_r, ch1_cnt_r, ch2_cnt_r, spare_cnt_r;

  // architectural state
  logic [3:0]          clk_ctl_r,  clk_ctl_nxt;
  logic [15:0]         trig_r,     trig_nxt;
  logic [15:0]         ctrl_r,     ctrl_nxt;
  logic [9:0]          upper_r,    upper_nxt;
  logic [9:0]          lower_r,    lower_nxt;
  logic [4:0]          imask_r,    imask_nxt;
  logic                adv_r,      adv_nxt;
  logic [9:0]          buf_r [CHANNELS];
  logic [9:0]          buf_nxt [CHANNELS];
  logic [9:0]          std_res_r,  std_res_nxt;
  logic                std_done_r, std_done_nxt;
  logic                std_ovr_r,  std_ovr_nxt;
  logic [CHANNELS-1:0] ch_done_r,  ch_done_nxt;
  logic [CHANNELS-1:0] ch_ovr_r,   ch_ovr_nxt;

  // sweep position
  logic [2:0] ch_r, ch_nxt;
  logic [2:0] last_r, last_nxt;

  // result staging and output register
  logic [15:0] res_rd_r, res_rd_nxt;
  logic        res_hit_r, res_hit_nxt;
  logic [15:0] out_rd_r;
  logic        out_hit_r;

  // decode
  logic          odd_byte, clk_hit, blk_hit, buf_sel, sweep_trig;
  logic [15:0]   lanes, value, ctrl_merged, ovr_clr, blk_rdata;
  logic [15:0]   upper_wr, lower_wr, imask_wr;
  logic [3:0]    reg_idx, buf_off;
  logic [2:0]    first_ch, last_raw, last_ch;
  logic [CH_W-1:0] step_idx;

  function automatic logic [15:0] merge(input logic [15:0] old, input logic [15:0] val,
                                        input logic [15:0] mask);
    merge = (old & ~mask) | (val & mask);
  endfunction

  function automatic logic [9:0] fixed_count(input logic [2:0] ch,
      input logic [9:0] c0, input logic [9:0] c1, input logic [9:0] c2,
      input logic [9:0] cs);
    if (ch == 3'd0)      fixed_count = c0;
    else if (ch == 3'd1) fixed_count = c1;
    else if (ch == 3'd2) fixed_count = c2;
    else                 fixed_count = cs;
  endfunction

  assign odd_byte    = (size_r == 3'd1) && addr_r[0];
  assign lanes       = (size_r == 3'd1) ? (addr_r[0] ? 16'hff00 : 16'h00ff) : 16'hffff;
  assign value       = odd_byte ? {wd_r[7:0], 8'h00} : wd_r;
  assign clk_hit     = (addr_r[11:1] == CLK_PAGE);
  assign blk_hit     = (addr_r[11:5] == BLK_PAGE) && (size_r == 3'd1 || size_r == 3'd2);
  assign reg_idx     = addr_r[4:1];
  assign buf_off     = reg_idx - REG_BUF0;
  assign buf_sel     = ({1'b0, reg_idx} >= {1'b0, REG_BUF0}) &&
                       ({1'b0, reg_idx} < 5'(32'(REG_BUF0) + CHANNELS));
  assign ctrl_merged = merge(ctrl_r, value, CTRL_WMASK & lanes);
  assign upper_wr    = merge({6'd0, upper_r}, value, LIM_WMASK & lanes);
  assign lower_wr    = merge({6'd0, lower_r}, value, LIM_WMASK & lanes);
  assign imask_wr    = merge({11'd0, imask_r}, value, IMASK_WMASK & lanes);
  assign ovr_clr     = ~value & lanes;
  assign first_ch    = trig_r[10:8];
  assign last_raw    = trig_r[13:11];
  assign last_ch     = ({1'b0, last_raw} >= 4'(CHANNELS)) ? 3'(CHANNELS - 1) : last_raw;
  assign step_idx    = ch_r[CH_W-1:0];

  // software-triggered start with enable
  assign sweep_trig = op_r && blk_hit && (reg_idx == REG_CTRL) &&
                      ctrl_merged[1] && ctrl_merged[2] && (trig_r[4:3] == 2'b00);

  assign stat.sweep_go   = sweep_trig && (first_ch <= last_ch);
  assign stat.sweep_last = (ch_r == last_r);

  always_comb begin
    unique case (reg_idx)
      REG_STD:   blk_rdata = {6'd0, std_res_r};
      REG_TRIG:  blk_rdata = trig_r;
      REG_CTRL:  blk_rdata = (ctrl_r & CTRL_WMASK) | {12'd0, std_done_r, 2'b00, std_ovr_r};
      REG_FLAGS: blk_rdata = {8'(ch_ovr_r), 8'(ch_done_r)};
      REG_UPPER: blk_rdata = {6'd0, upper_r};
      REG_LOWER: blk_rdata = {6'd0, lower_r};
      REG_IMASK: blk_rdata = {11'd0, imask_r};
      REG_ADV:   blk_rdata = {7'd0, adv_r, 8'd0};
      default:   blk_rdata = buf_sel ? {6'd0, buf_r[buf_off[CH_W-1:0]]} : 16'd0;
    endcase
  end

  always_comb begin
    clk_ctl_nxt  = clk_ctl_r;
    trig_nxt     = trig_r;
    ctrl_nxt     = ctrl_r;
    upper_nxt    = upper_r;
    lower_nxt    = lower_r;
    imask_nxt    = imask_r;
    adv_nxt      = adv_r;
    buf_nxt      = buf_r;
    std_res_nxt  = std_res_r;
    std_done_nxt = std_done_r;
    std_ovr_nxt  = std_ovr_r;
    ch_done_nxt  = ch_done_r;
    ch_ovr_nxt   = ch_ovr_r;
    ch_nxt       = ch_r;
    last_nxt     = last_r;
    res_rd_nxt   = res_rd_r;
    res_hit_nxt  = res_hit_r;

    if (cmd.exec) begin
      res_rd_nxt  = 16'd0;
      res_hit_nxt = clk_hit || blk_hit;
      if (clk_hit) begin
        if (op_r) begin
          if (!odd_byte) clk_ctl_nxt = value[3:0];
        end else begin
          res_rd_nxt = odd_byte ? 16'd0 : {12'd0, clk_ctl_r};
        end
      end else if (blk_hit) begin
        if (op_r) begin
          unique case (reg_idx)
            REG_TRIG: trig_nxt = merge(trig_r, value, TRIG_WMASK & lanes);
            REG_CTRL: begin
              ctrl_nxt = ctrl_merged;
              if (sweep_trig && !trig_r[5]) ctrl_nxt[1] = 1'b0;  // single mode
              if (lanes[0] && !value[0]) std_ovr_nxt = 1'b0;
            end
            REG_FLAGS: ch_ovr_nxt = ch_ovr_r & ~ovr_clr[8 +: CHANNELS];
            REG_UPPER: upper_nxt = upper_wr[9:0];
            REG_LOWER: lower_nxt = lower_wr[9:0];
            REG_IMASK: imask_nxt = imask_wr[4:0];
            REG_ADV:   if (lanes[8]) adv_nxt = value[8];
            default:   ;
          endcase
        end else begin
          res_rd_nxt = odd_byte ? {8'd0, blk_rdata[15:8]} : blk_rdata;
          if (buf_sel)                 ch_done_nxt[buf_off[CH_W-1:0]] = 1'b0;
          else if (reg_idx == REG_STD) std_done_nxt = 1'b0;
        end
      end
      ch_nxt   = first_ch;
      last_nxt = last_ch;
    end

    if (cmd.step) begin
      buf_nxt[step_idx]     = fixed_count(ch_r, ch0_cnt_r, ch1_cnt_r, ch2_cnt_r, spare_cnt_r);
      std_res_nxt           = buf_nxt[step_idx];
      std_ovr_nxt           = std_ovr_r | std_done_r;
      std_done_nxt          = 1'b1;
      ch_ovr_nxt[step_idx]  = ch_ovr_r[step_idx] | ch_done_r[step_idx];
      ch_done_nxt[step_idx] = 1'b1;
      ch_nxt                = ch_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch0_cnt_r   <= CH0_RESET;
      ch1_cnt_r   <= CH1_RESET;
      ch2_cnt_r   <= CH2_RESET;
      spare_cnt_r <= SPARE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CH0:   ch0_cnt_r   <= cfg_data;
        CFG_CH1:   ch1_cnt_r   <= cfg_data;
        CFG_CH2:   ch2_cnt_r   <= cfg_data;
        CFG_SPARE: spare_cnt_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_ctl_r  <= '0;
      trig_r     <= '0;
      ctrl_r     <= CTRL_RESET;
      upper_r    <= '0;
      lower_r    <= '0;
      imask_r    <= IMASK_RESET;
      adv_r      <= 1'b0;
      buf_r      <= '{default: '0};
      std_res_r  <= '0;
      std_done_r <= 1'b0;
      std_ovr_r  <= 1'b0;
      ch_done_r  <= '0;
      ch_ovr_r   <= '0;
    end else begin
      clk_ctl_r  <= clk_ctl_nxt;
      trig_r     <= trig_nxt;
      ctrl_r     <= ctrl_nxt;
      upper_r    <= upper_nxt;
      lower_r    <= lower_nxt;
      imask_r    <= imask_nxt;
      adv_r      <= adv_nxt;
      buf_r      <= buf_nxt;
      std_res_r  <= std_res_nxt;
      std_done_r <= std_done_nxt;
      std_ovr_r  <= std_ovr_nxt;
      ch_done_r  <= ch_done_nxt;
      ch_ovr_r   <= ch_ovr_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      addr_r <= in_address;
      size_r <= in_size;
      wd_r   <= in_write_data;
    end
    ch_r      <= ch_nxt;
    last_r    <= last_nxt;
    res_rd_r  <= res_rd_nxt;
    res_hit_r <= res_hit_nxt;
    if (cmd.emit) begin
      out_rd_r  <= res_rd_r;
      out_hit_r <= res_hit_r;
    end
  end

  assign out_read_data = out_rd_r;
  assign out_handled   = out_hit_r;

endmodule
